>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/rlh_pkg.sv
// Types and constants of the RGB/luma histogram block.
`default_nettype none

package rlh_pkg;

    localparam int BIN_W            = 8;
    localparam int BINS_PER_CHANNEL = 256;
    localparam int NUM_TABLES       = 4;
    localparam int TBL_W            = 2;
    localparam int OUT_W            = 32;

    // (r + g + b) / 3 as a multiply by reciprocal: floor(s * 683 / 2048)
    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;
    localparam int DIV3_SHIFT = 11;
    localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [TBL_W-1:0] {
        TBL_MASTER = 2'd0,
        TBL_RED    = 2'd1,
        TBL_GREEN  = 2'd2,
        TBL_BLUE   = 2'd3
    } tbl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/rgb_luma_histogram.sv
// Top level of the RGB/luma histogram: four count tables in block memories.
//
// Use of the block:
//   Slave channel s_axis carries commands: accumulate a pixel, read one bin,
//   or clear all tables. tuser holds the command and the table select,
//   tdata the ARGB pixel and the bin number, tlast flags a frame's last pixel.
//   Master channel m_axis returns one transfer for a read (the bin count) and
//   one for the last pixel of a frame (tlast high, count zero); tuser carries
//   the sticky saturation flag.
//   An accumulate or read is accepted in ST_IDLE, which issues the reads of
//   the four table memories; in ST_EXEC the registered read data comes in,
//   an accumulate writes back the bumped counts and a command with a result
//   loads the output register, which drives m_axis. The memory read is
//   registered. An unused command code leaves the block in ST_IDLE.
//   Reset and a clear command start a clearing pass over every row that
//   writes zeros to one row of all four memories per cycle; no transfer is
//   taken on s_axis during the pass.
//   A stalled receiver holds the result in the output register; the next
//   command is still taken, and one that has a result waits in ST_EXEC
//   until the output register frees up.
`default_nettype none

module rgb_luma_histogram #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // pixel_word[31:0], bin_index[39:32]
    input  wire logic [3:0]  s_axis_tuser,   // command[1:0], channel_select[3:2]
    input  wire logic        s_axis_tlast,   // last_pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // bin_count[31:0]
    output logic [0:0]       m_axis_tuser,   // any_saturated[0]
    output logic             m_axis_tlast    // frame_done
);

    import rlh_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Control and captured command
    state_t             state_reg, state_next;
    logic [BIN_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               sat_reg, sat_next;
    cmd_t               cmd_reg, cmd_next;
    logic               last_reg, last_next;
    tbl_t               chan_reg, chan_next;
    logic [BIN_W-1:0]   addr_reg [NUM_TABLES];
    logic [BIN_W-1:0]   addr_next [NUM_TABLES];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_sat_reg, out_sat_next;

    // Memory ports
    logic                   rd_en;
    logic [BIN_W-1:0]       rd_addr [NUM_TABLES];
    logic                   wr_en;
    logic [BIN_W-1:0]       wr_addr_tbl [NUM_TABLES];
    logic [COUNT_WIDTH-1:0] wr_data [NUM_TABLES];
    logic [COUNT_WIDTH-1:0] rd_data_reg [NUM_TABLES];

    // Datapath
    cmd_t                   in_cmd;
    logic [BIN_W-1:0]       pix_r, pix_g, pix_b;
    logic [SUM_W-1:0]       pix_sum;
    logic [PROD_W-1:0]      pix_prod;
    logic [BIN_W-1:0]       pix_avg;
    logic [COUNT_WIDTH-1:0] inc [NUM_TABLES];
    logic [NUM_TABLES-1:0]  hit;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic [OUT_W-1:0]       sel_clamped;
    logic                   need_result;
    logic                   out_free;

    assign in_cmd   = cmd_t'(s_axis_tuser[1:0]);
    assign pix_r    = s_axis_tdata[23:16];
    assign pix_g    = s_axis_tdata[15:8];
    assign pix_b    = s_axis_tdata[7:0];
    assign pix_sum  = SUM_W'(pix_r) + SUM_W'(pix_g) + SUM_W'(pix_b);
    assign pix_prod = PROD_W'(pix_sum) * PROD_W'(DIV3_MUL);
    assign pix_avg  = pix_prod[DIV3_SHIFT +: BIN_W];

    // Read addresses: each table at its own bin when accumulating, else the requested bin
    always_comb
    begin
        if (in_cmd == CMD_ACCUM)
        begin
            rd_addr[TBL_MASTER] = pix_avg;
            rd_addr[TBL_RED]    = pix_r;
            rd_addr[TBL_GREEN]  = pix_g;
            rd_addr[TBL_BLUE]   = pix_b;
        end
        else
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                rd_addr[t] = s_axis_tdata[39:32];
            end
        end
    end

    // Saturating increment of each read count
    always_comb
    begin
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            inc[t] = (rd_data_reg[t] == COUNT_MAX) ? rd_data_reg[t]
                                                   : rd_data_reg[t] + 1'b1;
            hit[t] = (inc[t] == COUNT_MAX);
        end
    end

    assign sel_count = rd_data_reg[chan_reg];

    // Clamp a wide count to the 32-bit result field, zero-extend a narrow one
    generate
        if (COUNT_WIDTH > OUT_W)
        begin : g_clamp
            assign sel_clamped = (|sel_count[COUNT_WIDTH-1:OUT_W]) ? '1
                                                                   : sel_count[OUT_W-1:0];
        end
        else
        begin : g_extend
            assign sel_clamped = OUT_W'(sel_count);
        end
    endgenerate

    // Table memories: one write and one registered read per cycle each
    generate
        for (genvar t = 0; t < NUM_TABLES; t++)
        begin : g_tbl
            logic [COUNT_WIDTH-1:0] bins_mem [BINS_PER_CHANNEL];

            always_ff @(posedge clk)
            begin
                if (wr_en)
                begin
                    bins_mem[wr_addr_tbl[t]] <= wr_data[t];
                end
                if (rd_en)
                begin
                    rd_data_reg[t] <= bins_mem[rd_addr[t]];
                end
            end
        end
    endgenerate

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sat_next       = sat_reg;
        cmd_next       = cmd_reg;
        last_next      = last_reg;
        chan_next      = chan_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_sat_next   = out_sat_reg;
        s_axis_tready  = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            wr_data[t] = inc[t];
        end

        need_result = (cmd_reg == CMD_READ) || ((cmd_reg == CMD_ACCUM) && last_reg);
        out_free    = !out_valid_reg || m_axis_tready;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one row of every table per cycle
                wr_en   = 1'b1;
                for (int t = 0; t < NUM_TABLES; t++)
                begin
                    wr_data[t] = '0;
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BIN_W'(BINS_PER_CHANNEL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    rd_en     = 1'b1;
                    cmd_next  = in_cmd;
                    last_next = s_axis_tlast;
                    chan_next = tbl_t'(s_axis_tuser[3:2]);
                    addr_next = rd_addr;
                    case (in_cmd)
                        CMD_ACCUM, CMD_READ:
                        begin
                            state_next = ST_EXEC;
                        end
                        CMD_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cnt_next = '0;
                            sat_next     = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                // Hold while a result has nowhere to go
                if (!need_result || out_free)
                begin
                    state_next = ST_IDLE;
                    if (cmd_reg == CMD_ACCUM)
                    begin
                        wr_en    = 1'b1;
                        sat_next = sat_reg || (|hit);
                    end
                    if (need_result)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = (cmd_reg == CMD_ACCUM);
                        out_data_next  = (cmd_reg == CMD_ACCUM) ? '0 : sel_clamped;
                        out_sat_next   = sat_next;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table writes use each table's own captured address during accumulate, the clear counter during a clear
    always_comb
    begin
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            wr_addr_tbl[t] = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg[t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        last_reg     <= last_next;
        chan_reg     <= chan_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_sat_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rlh_checker.sv
// Port-level checks of the RGB/luma histogram, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module rlh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [3:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    import rlh_pkg::*;

    logic s_xfer;
    logic clr_xfer;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign clr_xfer = s_xfer && (s_axis_tuser[1:0] == CMD_CLEAR);

    // A stalled result holds its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // Every command but the unused code takes the block out of ST_IDLE, so s_axis_tready drops once it is taken
    `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, s_xfer && (s_axis_tuser[1:0] != CMD_NOP),
                 !s_axis_tready)

    // s_axis_tready is still low at the end of the clearing pass after a clear is taken
    `ASSERT_IMPLIES(a_clear_len, clk, rst_n, clr_xfer, ##256 !s_axis_tready)

    // A frame-done result carries a zero count
    `ASSERT_IMPLIES(a_done_zero, clk, rst_n, m_axis_tvalid && m_axis_tlast,
                    m_axis_tdata == '0)

endmodule

bind rgb_luma_histogram rlh_checker u_rlh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
